/* rtl/dss_pkg.sv */
// dss_pkg: shared types, constants and the segment decode for the decimal
// seven-segment scan block.
// No dependencies.
package dss_pkg;

	// Places on the display; a 10-bit value never needs more than four
	localparam int DIGIT_COUNT = 4;
	localparam int MAX_PLACES  = 4;
	localparam int PLACES      = (DIGIT_COUNT < MAX_PLACES) ? DIGIT_COUNT : MAX_PLACES;

	localparam int VALUE_W = 10;
	localparam int CNT_W   = 3;   // holds 1..MAX_PLACES
	localparam int IDX_W   = 2;   // indexes MAX_PLACES places
	localparam int SEL_W   = 4;
	localparam int SEG_W   = 8;

	// Largest value with three, two and one digits
	localparam logic [VALUE_W-1:0] MAX_3DIG = 10'd999;
	localparam logic [VALUE_W-1:0] MAX_2DIG = 10'd99;
	localparam logic [VALUE_W-1:0] MAX_1DIG = 10'd9;

	// r / 100 == (r * 41) >> 12 for r below 1000
	localparam logic [15:0] HUND_RECIP = 16'd41;
	localparam int          HUND_SHIFT = 12;

	typedef logic [3:0] bcd_t;

	// One decoded value: its decimal digits and how many to show
	typedef struct packed {
		logic [CNT_W-1:0]         count;
		bcd_t [MAX_PLACES-1:0]    digits;
	} dss_entry_t;

	// Digit to segment pattern, bit 6 is segment a, bit 0 segment g
	function automatic logic [SEG_W-1:0] seg_decode(input bcd_t d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0: s = 8'h7E;
			4'd1: s = 8'h30;
			4'd2: s = 8'h6D;
			4'd3: s = 8'h79;
			4'd4: s = 8'h33;
			4'd5: s = 8'h5B;
			4'd6: s = 8'h5F;
			4'd7: s = 8'h70;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h7B;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

/* rtl/dss_if.sv */
// dss_if: valid/ready channel interfaces for values in and digit results out.
// Depends on dss_pkg.
interface dss_in_if import dss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink   (input valid, input sample_value, output ready);
endinterface

interface dss_out_if import dss_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEL_W-1:0] digit_select;
	logic [SEG_W-1:0] segments;
	logic             last_digit;

	modport source (output valid, output digit_select, output segments,
		output last_digit, input ready);
	modport sink   (input valid, input digit_select, input segments,
		input last_digit, output ready);
endinterface

/* rtl/dss_front.sv */
// dss_front: accepts values and splits them into decimal digits over two
// stages, pushing one entry per value into the queue.
// Depends on dss_pkg, dss_if.
module dss_front import dss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dss_in_if.sink      in_item,
	output logic        push_vld,
	input  logic        push_rdy,
	output dss_entry_t  push_data
);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PLACES);

	logic               vld_s1, vld_s2;
	logic [VALUE_W-1:0] v_s1;
	logic               th_s2;
	bcd_t               h_s2;
	logic [VALUE_W-1:0] r3_s2;
	logic [CNT_W-1:0]   cnt_s2;
	logic               en_s1, en_s2;

	logic               th;
	logic [VALUE_W-1:0] r3;
	logic [15:0]        h_prod;
	logic [CNT_W-1:0]   sig_cnt;
	logic [CNT_W-1:0]   cnt;

	logic [VALUE_W-1:0] r2_full;
	logic [6:0]         r2;
	bcd_t               tens;
	logic [6:0]         ones_full;

	// Stall chain: a stage loads when empty or when its contents move on
	assign en_s2         = !vld_s2 || push_rdy;
	assign en_s1         = !vld_s1 || en_s2;
	assign in_item.ready = en_s1;

	// Stage 1: thousands, remainder, hundreds estimate and digit count
	always_comb begin
		th      = (v_s1 > MAX_3DIG);
		r3      = th ? (v_s1 - 10'd1000) : v_s1;
		h_prod  = 16'(r3) * HUND_RECIP;
		if (v_s1 > MAX_3DIG)      sig_cnt = 3'd4;
		else if (v_s1 > MAX_2DIG) sig_cnt = 3'd3;
		else if (v_s1 > MAX_1DIG) sig_cnt = 3'd2;
		else                      sig_cnt = 3'd1;
		cnt = (sig_cnt > CNT_MAX) ? CNT_MAX : sig_cnt;
	end

	// Stage 2: tens and ones from the sub-hundred remainder
	always_comb begin
		r2_full = r3_s2 - (VALUE_W'(h_s2) * VALUE_W'(100));
		r2      = r2_full[6:0];
		tens    = '0;
		for (int k = 1; k < 10; k++) begin
			if (r2 >= 7'(k * 10)) tens = tens + 4'd1;
		end
		ones_full = r2 - (7'(tens) * 7'd10);
	end

	assign push_vld            = vld_s2;
	assign push_data.count     = cnt_s2;
	assign push_data.digits[0] = ones_full[3:0];
	assign push_data.digits[1] = tens;
	assign push_data.digits[2] = h_s2;
	assign push_data.digits[3] = {3'b000, th_s2};

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_item.valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en_s1 && in_item.valid) v_s1 <= in_item.sample_value;
		if (en_s2 && vld_s1) begin
			th_s2  <= th;
			h_s2   <= h_prod[HUND_SHIFT +: 4];
			r3_s2  <= r3;
			cnt_s2 <= cnt;
		end
	end

endmodule

/* rtl/dss_queue.sv */
// dss_queue: two-entry queue of decoded values between front and back.
// Depends on dss_pkg.
module dss_queue import dss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_vld,
	output logic       push_rdy,
	input  dss_entry_t push_data,
	output logic       pop_vld,
	input  logic       pop_rdy,
	output dss_entry_t pop_data
);

	dss_entry_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push, do_pop;

	assign push_rdy = (fill_q != 2'd2);
	assign pop_vld  = (fill_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = pop_vld && pop_rdy;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)      fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* rtl/dss_back.sv */
// dss_back: walks the digits of the head entry, ones first, one result per
// cycle into the output register while the output is not stalled.
// Depends on dss_pkg, dss_if.
module dss_back import dss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       invert_q,
	input  logic       pop_vld,
	output logic       pop_rdy,
	input  dss_entry_t pop_data,
	dss_out_if.source  out_item
);

	logic [IDX_W-1:0] idx_q;
	logic             out_vld_q;
	logic [SEL_W-1:0] sel_q;
	logic [SEG_W-1:0] seg_q;
	logic             last_q;
	logic             out_free;
	logic             emit;
	logic             is_last;
	logic [SEG_W-1:0] seg_raw;

	assign out_free = !out_vld_q || out_item.ready;
	assign emit     = pop_vld && out_free;
	assign is_last  = ((CNT_W'(idx_q) + 3'd1) == pop_data.count);
	assign pop_rdy  = emit && is_last;
	assign seg_raw  = seg_decode(pop_data.digits[idx_q]);

	assign out_item.valid        = out_vld_q;
	assign out_item.digit_select = sel_q;
	assign out_item.segments     = seg_q;
	assign out_item.last_digit   = last_q;

	// Digit index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_free) out_vld_q <= pop_vld;
			if (emit) idx_q <= is_last ? '0 : idx_q + 1'b1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			sel_q  <= SEL_W'(1) << idx_q;
			seg_q  <= invert_q ? ~seg_raw : seg_raw;
			last_q <= is_last;
		end
	end

endmodule

/* rtl/decimal_seven_segment_scan.sv */
// decimal_seven_segment_scan: top level; holds the inversion register and
// joins front, queue and back.
// Depends on dss_pkg, dss_if, dss_front, dss_queue, dss_back.
//
//  channel    dir  handshake         payload
//  in_item    in   valid/ready       sample_value[9:0]
//  out_item   out  valid/ready       digit_select[3:0], segments[7:0], last_digit
//  cfg        in   cfg_we            cfg_wdata = invert_segments
//
// One result per cycle leaves the back end while the output is not stalled,
// one result per shown digit (1 to 4); the back end's digit walk sets the
// sustained rate. The first result of a taken request passes the second
// front stage, the queue and the output register before it is valid.
// Reset clears all valids and sets inversion on.
// Either side may stall; the two-entry queue lets the front keep taking
// requests while the back end waits.
module decimal_seven_segment_scan import dss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dss_in_if.sink      in_item,
	dss_out_if.source   out_item,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	logic       invert_q;
	logic       push_vld, push_rdy, pop_vld, pop_rdy;
	dss_entry_t push_data, pop_data;

	// Segment inversion register, common-anode by default
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b1;
		end else if (cfg_we) begin
			invert_q <= cfg_wdata;
		end
	end

	dss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.push_vld  (push_vld),
		.push_rdy  (push_rdy),
		.push_data (push_data)
	);

	dss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (push_vld),
		.push_rdy  (push_rdy),
		.push_data (push_data),
		.pop_vld   (pop_vld),
		.pop_rdy   (pop_rdy),
		.pop_data  (pop_data)
	);

	dss_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.invert_q (invert_q),
		.pop_vld  (pop_vld),
		.pop_rdy  (pop_rdy),
		.pop_data (pop_data),
		.out_item (out_item)
	);

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for decimal_seven_segment_scan; predicts the digit
// results of every value request and checks them in order against the output.
// Depends on dss_pkg, dss_if and the decimal_seven_segment_scan RTL.
`timescale 1ns / 1ps

module tb_top;
	import dss_pkg::*;

	localparam int          WAIT_MAX     = 18;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          SETTLE_CYCLES = 8;
	localparam bit          SEG_INVERTED = 1'b1;
	localparam bit          SEG_DIRECT   = 1'b0;

	// Segment glyphs, digit 0 in the lowest byte
	localparam logic [79:0] GLYPHS = {8'h7B, 8'h7F, 8'h70, 8'h5F, 8'h5B,
		8'h33, 8'h79, 8'h6D, 8'h30, 8'h7E};

	typedef struct {
		logic [SEL_W-1:0] sel;
		logic [SEG_W-1:0] seg;
		logic             last;
	} digit_expect_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	dss_in_if  in_item();
	dss_out_if out_item();

	digit_expect_t pending_digits[$];
	bit            invert_cfg;
	int unsigned   mismatches;
	int unsigned   idle_cycles;
	int unsigned   in_gap_max;
	int unsigned   out_stall_max;

	decimal_seven_segment_scan i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Wait length for one request or result; at least a quarter of draws are back to back
	function automatic int unsigned draw_wait(input int unsigned limit);
		if (limit == 0 || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, limit);
	endfunction

	// Spread values evenly over one to four digit widths
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return VALUE_W'($urandom_range(0, 9));
			1: return VALUE_W'($urandom_range(10, 99));
			2: return VALUE_W'($urandom_range(100, 999));
			default: return VALUE_W'($urandom_range(1000, 1023));
		endcase
	endfunction

	// Split a value into shown digits, ones first, and queue the patterns
	function automatic void predict_digits(input logic [VALUE_W-1:0] v);
		int unsigned   rest;
		int unsigned   shown;
		int unsigned   d;
		digit_expect_t e;
		rest = v;
		if (v > 999)
			shown = 4;
		else if (v > 99)
			shown = 3;
		else if (v > 9)
			shown = 2;
		else
			shown = 1;
		if (shown > DIGIT_COUNT)
			shown = DIGIT_COUNT;
		for (int k = 0; k < shown; k++) begin
			d      = rest % 10;
			rest   = rest / 10;
			e.sel  = SEL_W'(1 << k);
			e.seg  = GLYPHS[d*8 +: 8] ^ {SEG_W{invert_cfg}};
			e.last = (k + 1 == shown);
			pending_digits.push_back(e);
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [7:0] got,
		input logic [7:0] want);
		$display("ERROR %0t: %s got %h expected %h", $realtime, field, got, want);
		mismatches++;
	endtask

	// Send one value request, with a random gap ahead of it
	task automatic send_value(input logic [VALUE_W-1:0] v);
		int unsigned gap;
		gap = draw_wait(in_gap_max);
		if (gap > 0) begin
			@(negedge clk);
			in_item.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_item.valid        <= 1'b1;
		in_item.sample_value <= v;
		do @(posedge clk); while (!in_item.ready);
		predict_digits(v);
	endtask

	// Drop valid and let every expected digit come out
	task automatic drain();
		@(negedge clk);
		in_item.valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_invert(input bit val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		invert_cfg = val;
	endtask

	// Reset polarity: widths, every glyph and the digit-count boundaries
	task automatic test_inverted_directed();
		logic [VALUE_W-1:0] vals[16];
		vals = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd8,
			10'd9, 10'd10, 10'd99, 10'd100, 10'd999, 10'd1000, 10'd1023};
		in_gap_max    = WAIT_MAX;
		out_stall_max = WAIT_MAX;
		foreach (vals[i])
			send_value(vals[i]);
		drain();
	endtask

	// Common-cathode polarity on the boundaries and a few mixed digits
	task automatic test_direct_directed();
		logic [VALUE_W-1:0] vals[8];
		vals = '{10'd0, 10'd9, 10'd10, 10'd999, 10'd1000, 10'd1023, 10'd345,
			10'd876};
		write_invert(SEG_DIRECT);
		foreach (vals[i])
			send_value(vals[i]);
		drain();
	endtask

	task automatic run_random(input bit pol, input int unsigned gaps,
		input int unsigned stalls, input int unsigned n);
		write_invert(pol);
		in_gap_max    = gaps;
		out_stall_max = stalls;
		repeat (n)
			send_value(pick_value());
		drain();
	endtask

	task automatic test_random_idling();
		run_random(SEG_INVERTED, WAIT_MAX, WAIT_MAX, 150);
	endtask

	task automatic test_random_full_rate();
		run_random(SEG_DIRECT, 0, 0, 100);
	endtask

	task automatic test_random_output_stalls();
		run_random(SEG_INVERTED, 0, WAIT_MAX, 90);
	endtask

	task automatic test_random_input_gaps();
		run_random(SEG_DIRECT, WAIT_MAX, 0, 90);
	endtask

	// Output ready: random stall before each result
	initial begin
		int unsigned stall;
		out_item.ready = 1'b0;
		forever begin
			stall = draw_wait(out_stall_max);
			if (stall > 0) begin
				@(negedge clk);
				out_item.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_item.ready <= 1'b1;
			do @(posedge clk); while (!(out_item.valid && out_item.ready));
		end
	end

	// Compare each digit result with the oldest expectation
	always @(posedge clk) begin
		digit_expect_t e;
		if (arst_n && out_item.valid && out_item.ready) begin
			if (pending_digits.size() == 0) begin
				report_mismatch("unexpected result, segments",
					out_item.segments, 8'h00);
			end else begin
				e = pending_digits.pop_front();
				if (out_item.digit_select !== e.sel)
					report_mismatch("digit_select", 8'(out_item.digit_select), 8'(e.sel));
				if (out_item.segments !== e.seg)
					report_mismatch("segments", out_item.segments, e.seg);
				if (out_item.last_digit !== e.last)
					report_mismatch("last_digit", 8'(out_item.last_digit), 8'(e.last));
			end
		end
	end

	// Watchdog on cycles with no request and no result
	always @(posedge clk) begin
		if (!arst_n || (in_item.valid && in_item.ready) ||
			(out_item.valid && out_item.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("decimal_seven_segment_scan: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = 1'b0;
		in_item.valid        = 1'b0;
		in_item.sample_value = '0;
		invert_cfg           = SEG_INVERTED;
		mismatches           = 0;
		idle_cycles          = 0;
		in_gap_max           = WAIT_MAX;
		out_stall_max        = WAIT_MAX;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_inverted_directed();
		test_direct_directed();
		test_random_idling();
		test_random_full_rate();
		test_random_output_stalls();
		test_random_input_gaps();

		if (mismatches == 0)
			$display("decimal_seven_segment_scan: match");
		else
			$display("decimal_seven_segment_scan: mismatch");
		$finish;
	end

endmodule

/* files.f */
rtl/dss_pkg.sv
rtl/dss_if.sv
rtl/dss_front.sv
rtl/dss_queue.sv
rtl/dss_back.sv
rtl/decimal_seven_segment_scan.sv
bench/tb_top.sv
